### src/ata_pio_disk_target_assert.svh
// Assertion macros used by the disk target back end.
`ifndef ATA_PIO_DISK_TARGET_ASSERT_SVH
`define ATA_PIO_DISK_TARGET_ASSERT_SVH
// Condition that must hold at every clock edge out of reset.
`define APDT_CHECK(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Condition that, once true, forces a consequence in the next cycle.
`define APDT_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### src/apdt_pkg.sv
// Types and constants of the ATA PIO disk target.
`default_nettype none
package apdt_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Task file offsets.
    localparam logic [2:0] OFF_DATA   = 3'd0;
    localparam logic [2:0] OFF_ERROR  = 3'd1;
    localparam logic [2:0] OFF_COUNT  = 3'd2;
    localparam logic [2:0] OFF_LBA_LO = 3'd3;
    localparam logic [2:0] OFF_LBA_MI = 3'd4;
    localparam logic [2:0] OFF_LBA_HI = 3'd5;
    localparam logic [2:0] OFF_DRIVE  = 3'd6;
    localparam logic [2:0] OFF_CMD    = 3'd7;

    // Status and error bits.
    localparam logic [7:0] ST_DRDY  = 8'h40;
    localparam logic [7:0] ST_DRQ   = 8'h08;
    localparam logic [7:0] ST_ERR   = 8'h01;
    localparam logic [7:0] ERR_IDNF = 8'h10;
    localparam logic [7:0] ERR_ABRT = 8'h04;

    // Command codes.
    localparam logic [7:0] CMD_READ     = 8'h20;
    localparam logic [7:0] CMD_WRITE    = 8'h30;
    localparam logic [7:0] CMD_FLUSH    = 8'hE7;
    localparam logic [7:0] CMD_IDENTIFY = 8'hEC;

    localparam logic [7:0] DRIVE_RESET = 8'hA0;

    // Configuration register indexes.
    localparam logic CFG_REPORTED = 1'b0;
    localparam logic CFG_MASTER   = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_READ  = 2'd1,
        PH_WRITE = 2'd2,
        PH_IDENT = 2'd3
    } phase_t;

    // Request class assigned by the front end.
    typedef enum logic [2:0] {
        K_NOP     = 3'd0,
        K_DATA_RD = 3'd1,
        K_DATA_WR = 3'd2,
        K_REG_RD  = 3'd3,
        K_REG_WR  = 3'd4,
        K_CMD     = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  off;
        logic [15:0] data;
    } item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [7:0]  status_now;
    } result_t;

endpackage
`default_nettype wire

### src/apdt_fifo.sv
// Small register queue used between the parts of the disk target.
`default_nettype none
module apdt_fifo #(
    parameter int W = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr,
    input  wire logic [W-1:0]                wdata,
    input  wire logic                        rd,
    output logic [W-1:0]                     rdata,
    output logic                             full,
    output logic                             empty,
    output logic [apdt_pkg::Q_CNT_W-1:0]     count
);
    import apdt_pkg::*;

    logic [W-1:0]       slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    // Handshake qualification and pointer update.
    always_comb
    begin
        do_wr    = wr && !full;
        do_rd    = rd && !empty;
        wp_next  = do_wr ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_rd ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + {{(Q_CNT_W-1){1'b0}}, do_wr} - {{(Q_CNT_W-1){1'b0}}, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Payload slots need no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wp_reg] <= wdata;
        end
    end

    assign rdata = slot_reg[rp_reg];
    assign full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;
endmodule
`default_nettype wire

### src/apdt_front.sv
// Front end: accepts host requests, classifies them and queues them.
`default_nettype none
module apdt_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic           req_type,
    input  wire logic [2:0]     reg_offset,
    input  wire logic [15:0]    write_data,
    input  wire logic           take,
    output apdt_pkg::item_t     item,
    output logic                avail
);
    import apdt_pkg::*;

    item_t              cls;
    logic               q_empty;
    logic [Q_CNT_W-1:0] q_count;

    // Classify the request by direction and offset.
    always_comb
    begin
        cls.off  = reg_offset;
        cls.data = write_data;
        if (req_type)
        begin
            case (reg_offset)
                OFF_DATA:  cls.kind = K_DATA_WR;
                OFF_ERROR: cls.kind = K_NOP;
                OFF_CMD:   cls.kind = K_CMD;
                default:   cls.kind = K_REG_WR;
            endcase
        end
        else
        begin
            cls.kind = (reg_offset == OFF_DATA) ? K_DATA_RD : K_REG_RD;
        end
    end

    apdt_fifo #(.W($bits(item_t))) u_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push),
        .wdata (cls),
        .rd    (take),
        .rdata (item),
        .full  (full),
        .empty (q_empty),
        .count (q_count)
    );

    assign avail = !q_empty && (q_count != '0);
endmodule
`default_nettype wire

### src/apdt_back.sv
// Back end: task file, transfer engine, sector store and result queue.
`default_nettype none
module apdt_back #(
    parameter int STORE_SECTORS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire apdt_pkg::item_t item,
    input  wire logic           avail,
    output logic                take,
    input  wire logic           cfg_we,
    input  wire logic           cfg_addr,
    input  wire logic [27:0]    cfg_wdata,
    input  wire logic           pop,
    output logic                empty,
    output logic [15:0]         read_data,
    output logic [7:0]          status_now
);
    import apdt_pkg::*;

    localparam int SEC_W = (STORE_SECTORS > 1) ? $clog2(STORE_SECTORS) : 1;
    localparam int AW = SEC_W + 8;
    localparam int STORE_WORDS = STORE_SECTORS * 256;
    localparam logic [28:0] STORE_LIM = 29'(STORE_SECTORS);

    // Configuration registers.
    logic [27:0] rep_reg;
    logic        master_reg;

    // Task file and transfer state.
    logic [7:0]  count_reg, count_next, lo_reg, lo_next, mi_reg, mi_next;
    logic [7:0]  hi_reg, hi_next, drive_reg, drive_next;
    logic [7:0]  status_reg, status_next, error_reg, error_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  word_reg, word_next;
    logic [8:0]  left_reg, left_next;
    logic [27:0] lba_reg, lba_next;

    // Second stage: waits for the store read data.
    logic        s2_v_reg, s2_mem_reg;
    logic [15:0] s2_rd_reg;
    logic [7:0]  s2_st_reg;

    logic [15:0] store [STORE_WORDS];
    logic [15:0] mem_q;
    logic [AW-1:0] addr;
    logic        mem_we, mem_re, use_mem, adv, live;
    logic [15:0] rd_val;
    logic [27:0] cmd_lba;
    logic [8:0]  cmd_n;
    logic [28:0] cmd_end;
    logic [7:0]  cmd;
    logic [7:0]  st_after;

    result_t     res_in, res_out;
    logic        oq_full;
    logic [Q_CNT_W-1:0] oq_count;

    // Issue only when the result queue has room for this and the item in flight.
    assign take = avail && ((oq_count + {{(Q_CNT_W-1){1'b0}}, s2_v_reg}) < Q_CNT_W'(Q_DEPTH));

    assign live    = master_reg && !drive_reg[4];
    assign addr    = {lba_reg[SEC_W-1:0], word_reg};
    assign cmd     = item.data[7:0];
    assign cmd_lba = {drive_reg[3:0], hi_reg, mi_reg, lo_reg};
    assign cmd_n   = (count_reg == 8'd0) ? 9'd256 : {1'b0, count_reg};
    assign cmd_end = {1'b0, cmd_lba} + {20'd0, cmd_n};

    // Execute one request against the task file.
    always_comb
    begin
        count_next  = count_reg;
        lo_next     = lo_reg;
        mi_next     = mi_reg;
        hi_next     = hi_reg;
        drive_next  = drive_reg;
        status_next = status_reg;
        error_next  = error_reg;
        phase_next  = phase_reg;
        word_next   = word_reg;
        left_next   = left_reg;
        lba_next    = lba_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        use_mem     = 1'b0;
        adv         = 1'b0;
        rd_val      = 16'd0;
        if (take)
        begin
            case (item.kind)
                K_DATA_WR:
                begin
                    if (live && phase_reg == PH_WRITE)
                    begin
                        mem_we = 1'b1;
                        adv    = 1'b1;
                    end
                end
                K_DATA_RD:
                begin
                    if (live && phase_reg == PH_READ)
                    begin
                        mem_re  = 1'b1;
                        use_mem = 1'b1;
                        adv     = 1'b1;
                    end
                    else if (live && phase_reg == PH_IDENT)
                    begin
                        if (word_reg == 8'd60)
                        begin
                            rd_val = rep_reg[15:0];
                        end
                        else if (word_reg == 8'd61)
                        begin
                            rd_val = {4'd0, rep_reg[27:16]};
                        end
                        adv = 1'b1;
                    end
                end
                K_REG_WR:
                begin
                    case (item.off)
                        OFF_COUNT:  count_next = item.data[7:0];
                        OFF_LBA_LO: lo_next    = item.data[7:0];
                        OFF_LBA_MI: mi_next    = item.data[7:0];
                        OFF_LBA_HI: hi_next    = item.data[7:0];
                        OFF_DRIVE:  drive_next = item.data[7:0];
                        default:    ;
                    endcase
                end
                K_CMD:
                begin
                    if (live)
                    begin
                        case (cmd)
                            CMD_READ, CMD_WRITE:
                            begin
                                if (cmd_end > STORE_LIM)
                                begin
                                    phase_next  = PH_IDLE;
                                    status_next = ST_DRDY | ST_ERR;
                                    error_next  = ERR_IDNF;
                                end
                                else
                                begin
                                    phase_next  = (cmd == CMD_READ) ? PH_READ : PH_WRITE;
                                    lba_next    = cmd_lba;
                                    left_next   = cmd_n;
                                    word_next   = 8'd0;
                                    status_next = ST_DRDY | ST_DRQ;
                                    error_next  = 8'd0;
                                end
                            end
                            CMD_IDENTIFY:
                            begin
                                phase_next  = PH_IDENT;
                                word_next   = 8'd0;
                                status_next = ST_DRDY | ST_DRQ;
                                error_next  = 8'd0;
                            end
                            CMD_FLUSH:
                            begin
                                phase_next  = PH_IDLE;
                                status_next = ST_DRDY;
                                error_next  = 8'd0;
                            end
                            default:
                            begin
                                phase_next  = PH_IDLE;
                                status_next = ST_DRDY | ST_ERR;
                                error_next  = ERR_ABRT;
                            end
                        endcase
                    end
                end
                K_REG_RD:
                begin
                    if (live)
                    begin
                        case (item.off)
                            OFF_ERROR:  rd_val = {8'd0, error_reg};
                            OFF_COUNT:  rd_val = {8'd0, count_reg};
                            OFF_LBA_LO: rd_val = {8'd0, lo_reg};
                            OFF_LBA_MI: rd_val = {8'd0, mi_reg};
                            OFF_LBA_HI: rd_val = {8'd0, hi_reg};
                            OFF_DRIVE:  rd_val = {8'd0, drive_reg};
                            default:    rd_val = {8'd0, status_reg};
                        endcase
                    end
                end
                default: ;
            endcase

            // Step to the next word; a sector boundary ends or continues the transfer.
            if (adv)
            begin
                word_next = word_reg + 8'd1;
                if (word_reg == 8'hFF)
                begin
                    if (phase_reg == PH_IDENT)
                    begin
                        phase_next  = PH_IDLE;
                        status_next = ST_DRDY;
                    end
                    else
                    begin
                        left_next = left_reg - 9'd1;
                        lba_next  = lba_reg + 28'd1;
                        if (left_reg == 9'd1)
                        begin
                            phase_next  = PH_IDLE;
                            status_next = ST_DRDY;
                        end
                    end
                end
            end
        end
        st_after = (master_reg && !drive_next[4]) ? status_next : 8'd0;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_reg    <= 28'd16;
            master_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_REPORTED)
            begin
                rep_reg <= cfg_wdata;
            end
            else
            begin
                master_reg <= cfg_wdata[0];
            end
        end
    end

    // Task file and transfer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            lo_reg     <= '0;
            mi_reg     <= '0;
            hi_reg     <= '0;
            drive_reg  <= DRIVE_RESET;
            status_reg <= ST_DRDY;
            error_reg  <= '0;
            phase_reg  <= PH_IDLE;
            word_reg   <= '0;
            left_reg   <= '0;
            lba_reg    <= '0;
            s2_v_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            lo_reg     <= lo_next;
            mi_reg     <= mi_next;
            hi_reg     <= hi_next;
            drive_reg  <= drive_next;
            status_reg <= status_next;
            error_reg  <= error_next;
            phase_reg  <= phase_next;
            word_reg   <= word_next;
            left_reg   <= left_next;
            lba_reg    <= lba_next;
            s2_v_reg   <= take;
        end
    end

    // Second stage payload.
    always_ff @(posedge clk)
    begin
        s2_mem_reg <= use_mem;
        s2_rd_reg  <= rd_val;
        s2_st_reg  <= st_after;
    end

    // Sector store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[addr] <= item.data;
        end
        if (mem_re)
        begin
            mem_q <= store[addr];
        end
    end

    assign res_in.read_data  = s2_mem_reg ? mem_q : s2_rd_reg;
    assign res_in.status_now = s2_st_reg;

    apdt_fifo #(.W($bits(result_t))) u_oq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (s2_v_reg),
        .wdata (res_in),
        .rd    (pop),
        .rdata (res_out),
        .full  (oq_full),
        .empty (empty),
        .count (oq_count)
    );

    assign read_data  = res_out.read_data;
    assign status_now = res_out.status_now;

    `include "ata_pio_disk_target_assert.svh"

    `APDT_CHECK(a_no_overflow, !(s2_v_reg && oq_full), "result queue overflow")
    `APDT_CHECK(a_drq_phase, (phase_reg != PH_IDLE) == ((status_reg & ST_DRQ) != 8'd0), "DRQ mismatch")
    `APDT_CHECK(a_left_nonzero, !((phase_reg == PH_READ || phase_reg == PH_WRITE) && left_reg == 9'd0), "empty transfer")
endmodule
`default_nettype wire

### src/ata_pio_disk_target.sv
// Top level of the ATA PIO disk target (28-bit LBA device side).
//
// Requests enter through a queue port: a request is taken at a clock edge
// with push high and full low. Each request is one task file access
// (req_type, reg_offset, write_data). Every request yields exactly one
// result (read_data, status_now), offered while empty is low and taken at
// an edge with pop high. Results leave in request order.
// A request passes the request queue, the execute logic, the second stage
// registers and the result queue before its result shows; one request per
// cycle is sustained while pop keeps up, set by the execute stage and the
// one read port of the sector store. If pop is held low, the four-entry
// result queue and then the four-entry request queue fill, after which full
// rises; nothing is dropped. Configuration (reported sector count, master
// present) is written through cfg_we, cfg_addr and cfg_wdata; the user
// must do so only while no request is in flight; it is not enforced.
// Reset clears the task file to its power-on values (status DRDY, drive
// 0xA0), empties both queues and needs no sweep of the sector store.
`default_nettype none
module ata_pio_disk_target #(
    parameter int STORE_SECTORS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        req_type,
    input  wire logic [2:0]  reg_offset,
    input  wire logic [15:0] write_data,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      read_data,
    output logic [7:0]       status_now,
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [27:0] cfg_wdata
);
    import apdt_pkg::*;

    item_t item;
    logic  avail, take;

    apdt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .reg_offset (reg_offset),
        .write_data (write_data),
        .take       (take),
        .item       (item),
        .avail      (avail)
    );

    apdt_back #(.STORE_SECTORS(STORE_SECTORS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .avail      (avail),
        .take       (take),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .pop        (pop),
        .empty      (empty),
        .read_data  (read_data),
        .status_now (status_now)
    );
endmodule
`default_nettype wire
